/* hw/rtl/smbt_pkg.sv */
// Shared types and constants for the SPI master byte transfer block.
// No dependencies; imported by every other file of the block.
package smbt_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_WRITE_DATA   = 3'd0;
  localparam logic [2:0] REQ_READ_DATA    = 3'd1;
  localparam logic [2:0] REQ_READ_STATUS  = 3'd2;
  localparam logic [2:0] REQ_WRITE_STATUS = 3'd3;
  localparam logic [2:0] REQ_TICK         = 3'd4;

  // Status byte layout (read status, write-one-to-clear)
  localparam int STATUS_DONE_BIT = 7;
  localparam int STATUS_COLL_BIT = 6;

  // Configuration register indexes
  localparam int          CFG_IDX_W          = 3;
  localparam int          CFG_DATA_W         = 2;
  localparam logic [2:0]  CFG_SPI_ENABLE     = 3'd0;
  localparam logic [2:0]  CFG_LSB_FIRST      = 3'd1;
  localparam logic [2:0]  CFG_CLOCK_POLARITY = 3'd2;
  localparam logic [2:0]  CFG_CLOCK_PHASE    = 3'd3;
  localparam logic [2:0]  CFG_RATE_SELECT    = 3'd4;

  // Prescaler counter width (largest half period is 64 ticks)
  localparam int PRESCALE_W = 7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] write_data;
    logic       serial_data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       serial_clock;
    logic       serial_data_out;
    logic       done_flag;
    logic       collision_flag;
    logic       busy_out;
  } out_item_t;

  // Configuration write bundle passed from the top level to the engine
  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Half period of the serial clock in ticks, per rate select code
  function automatic logic [PRESCALE_W:0] half_period(input logic [1:0] sel);
    logic [PRESCALE_W:0] hp;
    case (sel)
      2'd0:    hp = 8'd2;
      2'd1:    hp = 8'd8;
      2'd2:    hp = 8'd32;
      default: hp = 8'd64;
    endcase
    return hp;
  endfunction

endpackage

/* hw/rtl/smbt_engine.sv */
// Serial engine: configuration registers, shift register, prescaler and flags.
// Handles one accepted item per cycle and produces its result. Uses smbt_pkg.
module smbt_engine #(
  parameter int DATA_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_acc,
  input  smbt_pkg::in_item_t  item,
  input  smbt_pkg::cfg_wr_t   cfg_wr,
  output smbt_pkg::out_item_t res
);
  import smbt_pkg::*;

  localparam int BL_W = $clog2(DATA_BITS + 1);

  // Configuration registers
  logic             spi_enable_r, lsb_first_r, cpol_r, cpha_r;
  logic [1:0]       rate_select_r;
  logic             spi_enable_nxt, lsb_first_nxt, cpol_nxt, cpha_nxt;
  logic [1:0]       rate_select_nxt;

  // Transfer state
  logic [DATA_BITS-1:0]  shift_r, shift_nxt;
  logic [DATA_BITS-1:0]  rx_r, rx_nxt;
  logic [BL_W-1:0]       bits_left_r, bits_left_nxt;
  logic [PRESCALE_W-1:0] prescale_r, prescale_nxt;
  logic clock_level_r, clock_level_nxt;
  logic done_r, done_nxt;
  logic coll_r, coll_nxt;
  logic running_r, running_nxt;
  logic mosi_r, mosi_nxt;
  logic sample_r, sample_nxt;

  logic [DATA_BITS+7:0] load_ext;
  logic [DATA_BITS+7:0] rx_ext;
  logic [PRESCALE_W:0]  prescale_inc;
  logic [7:0]           rd;

  function automatic logic out_bit(input logic [DATA_BITS-1:0] s, input logic lsb);
    return lsb ? s[0] : s[DATA_BITS-1];
  endfunction

  function automatic logic [DATA_BITS-1:0] shift_in(input logic [DATA_BITS-1:0] s,
                                                    input logic lsb, input logic b);
    return lsb ? {b, s[DATA_BITS-1:1]} : {s[DATA_BITS-2:0], b};
  endfunction

  assign load_ext     = {{DATA_BITS{1'b0}}, item.write_data};
  assign rx_ext       = {8'h00, rx_r};
  assign prescale_inc = {1'b0, prescale_r} + 1'b1;

  // Next-state and result for the accepted item, then config writes
  always_comb begin
    spi_enable_nxt  = spi_enable_r;
    lsb_first_nxt   = lsb_first_r;
    cpol_nxt        = cpol_r;
    cpha_nxt        = cpha_r;
    rate_select_nxt = rate_select_r;
    shift_nxt       = shift_r;
    rx_nxt          = rx_r;
    bits_left_nxt   = bits_left_r;
    prescale_nxt    = prescale_r;
    clock_level_nxt = clock_level_r;
    done_nxt        = done_r;
    coll_nxt        = coll_r;
    running_nxt     = running_r;
    mosi_nxt        = mosi_r;
    sample_nxt      = sample_r;
    rd              = 8'h00;

    if (item_acc) begin
      case (item.req_type)
        REQ_WRITE_DATA: begin
          if (running_r) begin
            coll_nxt = 1'b1;
          end else if (spi_enable_r) begin
            shift_nxt       = load_ext[DATA_BITS-1:0];
            running_nxt     = 1'b1;
            bits_left_nxt   = BL_W'(DATA_BITS);
            prescale_nxt    = '0;
            clock_level_nxt = 1'b0;
            if (!cpha_r) mosi_nxt = out_bit(load_ext[DATA_BITS-1:0], lsb_first_r);
          end
        end
        REQ_READ_DATA: begin
          rd = rx_ext[7:0];
        end
        REQ_READ_STATUS: begin
          rd[STATUS_DONE_BIT] = done_r;
          rd[STATUS_COLL_BIT] = coll_r;
        end
        REQ_WRITE_STATUS: begin
          if (item.write_data[STATUS_DONE_BIT]) done_nxt = 1'b0;
          if (item.write_data[STATUS_COLL_BIT]) coll_nxt = 1'b0;
        end
        REQ_TICK: begin
          if (running_r) begin
            if (prescale_inc >= half_period(rate_select_r)) begin
              prescale_nxt = '0;
              if (!clock_level_r) begin
                // leading edge
                clock_level_nxt = 1'b1;
                if (cpha_r) begin
                  mosi_nxt = out_bit(shift_r, lsb_first_r);
                end else begin
                  sample_nxt = item.serial_data_in;
                  if (bits_left_r != '0) bits_left_nxt = bits_left_r - BL_W'(1);
                end
              end else begin
                // trailing edge
                clock_level_nxt = 1'b0;
                if (cpha_r) begin
                  shift_nxt = shift_in(shift_r, lsb_first_r, item.serial_data_in);
                  if (bits_left_r != '0) bits_left_nxt = bits_left_r - BL_W'(1);
                end else begin
                  shift_nxt = shift_in(shift_r, lsb_first_r, sample_r);
                end
                if (bits_left_nxt == '0) begin
                  running_nxt = 1'b0;
                  rx_nxt      = shift_nxt;
                  done_nxt    = 1'b1;
                end else if (!cpha_r) begin
                  mosi_nxt = out_bit(shift_nxt, lsb_first_r);
                end
              end
            end else begin
              prescale_nxt = prescale_inc[PRESCALE_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Configuration writes; clearing enable aborts a running transfer
    if (cfg_wr.en) begin
      case (cfg_wr.index)
        CFG_SPI_ENABLE: begin
          spi_enable_nxt = cfg_wr.data[0];
          if (!cfg_wr.data[0] && running_nxt) begin
            running_nxt     = 1'b0;
            clock_level_nxt = 1'b0;
            bits_left_nxt   = '0;
            prescale_nxt    = '0;
          end
        end
        CFG_LSB_FIRST:      lsb_first_nxt   = cfg_wr.data[0];
        CFG_CLOCK_POLARITY: cpol_nxt        = cfg_wr.data[0];
        CFG_CLOCK_PHASE:    cpha_nxt        = cfg_wr.data[0];
        CFG_RATE_SELECT:    rate_select_nxt = cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  // Result taken after the item's state update
  always_comb begin
    res.read_data       = rd;
    res.serial_clock    = clock_level_nxt ^ cpol_nxt;
    res.serial_data_out = mosi_nxt;
    res.done_flag       = done_nxt;
    res.collision_flag  = coll_nxt;
    res.busy_out        = running_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spi_enable_r  <= 1'b0;
      lsb_first_r   <= 1'b0;
      cpol_r        <= 1'b0;
      cpha_r        <= 1'b0;
      rate_select_r <= 2'd0;
      shift_r       <= '0;
      rx_r          <= '0;
      bits_left_r   <= '0;
      prescale_r    <= '0;
      clock_level_r <= 1'b0;
      done_r        <= 1'b0;
      coll_r        <= 1'b0;
      running_r     <= 1'b0;
      mosi_r        <= 1'b0;
      sample_r      <= 1'b0;
    end else begin
      spi_enable_r  <= spi_enable_nxt;
      lsb_first_r   <= lsb_first_nxt;
      cpol_r        <= cpol_nxt;
      cpha_r        <= cpha_nxt;
      rate_select_r <= rate_select_nxt;
      shift_r       <= shift_nxt;
      rx_r          <= rx_nxt;
      bits_left_r   <= bits_left_nxt;
      prescale_r    <= prescale_nxt;
      clock_level_r <= clock_level_nxt;
      done_r        <= done_nxt;
      coll_r        <= coll_nxt;
      running_r     <= running_nxt;
      mosi_r        <= mosi_nxt;
      sample_r      <= sample_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Idle engine holds no pending bits and leaves the clock in its idle half
  a_idle_bits: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (bits_left_r == '0))
    else $error("bits left while no transfer runs");
  a_idle_clock: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> !clock_level_r)
    else $error("serial clock active while no transfer runs");
  a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(running_r))
    else $error("done flag set without a running transfer");
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_left_r <= BL_W'(DATA_BITS))
    else $error("bit counter out of range");
`endif

endmodule

/* hw/rtl/smbt_out_buf.sv */
// Two-entry output buffer (output register plus skid register) for results.
// Lets the engine take a new item while a result waits. Uses smbt_pkg.
module smbt_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  smbt_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output smbt_pkg::out_item_t out_item
);
  import smbt_pkg::*;

  out_item_t main_r, skid_r;
  logic      main_vld_r, skid_vld_r;
  logic      pop;

  assign pop       = main_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_item  = main_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      main_vld_r <= skid_vld_r || push;
      skid_vld_r <= skid_vld_r && push;
    end else if (push) begin
      main_vld_r <= 1'b1;
      skid_vld_r <= main_vld_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_vld_r) begin
        main_r <= skid_r;
        if (push) skid_r <= push_item;
      end else if (push) begin
        main_r <= push_item;
      end
    end else if (push) begin
      if (main_vld_r) skid_r <= push_item;
      else main_r <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid entry held with empty output register");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("result pushed into a full buffer");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (main_vld_r && out_stall && !skid_vld_r && push) |=> skid_vld_r)
    else $error("stalled result lost its follower");
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (main_vld_r && !out_stall && skid_vld_r && !push) |=> (main_vld_r && !skid_vld_r))
    else $error("skid entry not moved to output register");
`endif

endmodule

/* hw/rtl/spi_master_byte_transfer.sv */
// SPI master, modes 0 to 3, one word per transfer: top level.
// Instantiates smbt_engine and smbt_out_buf; uses smbt_pkg.
//
// Usage: every request (data/status read or write, or clock tick) is one item
// on the in_ channel and yields exactly one result item on the out_ channel.
// The block takes one item per clock cycle while in_stall is low; the engine
// updates its state in the cycle an item is accepted and the result enters
// the output register, or the skid register while an earlier result waits,
// so the block keeps accepting; in_stall rises only when both entries are held.
// The serial clock period is 4, 16, 64 or 128 tick items per rate_select.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
// and should be issued while no results are outstanding.
module spi_master_byte_transfer #(
  parameter int DATA_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  smbt_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output smbt_pkg::out_item_t                  out_item,
  input  logic                                 cfg_wr_en,
  input  logic [smbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smbt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import smbt_pkg::*;

  logic      item_acc;
  logic      buf_full;
  cfg_wr_t   cfg_wr;
  out_item_t res;

  assign in_stall     = buf_full;
  assign item_acc     = in_valid && !buf_full;
  assign cfg_wr.en    = cfg_wr_en;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  smbt_engine #(
    .DATA_BITS(DATA_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .item     (in_item),
    .cfg_wr   (cfg_wr),
    .res      (res)
  );

  smbt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_acc),
    .push_item (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* dv/spi_master_byte_transfer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for spi_master_byte_transfer: bus requests and clock
// ticks go in as items, a scoreboard class predicts each reply and checks it.
// Depends on smbt_pkg and the block's RTL only.
module spi_master_byte_transfer_tb;
  import smbt_pkg::*;

  localparam int DATA_BITS      = 8;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int GAP_PERCENT    = 37;

  // Stretch of the random items sent with no idling on either side
  localparam int NO_GAP_FIRST   = 400;
  localparam int NO_GAP_LAST    = 700;

  // Request codes the block does not define
  localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
  localparam logic [2:0] REQ_RESERVED_HI = 3'd7;

  // Scoreboard: mirror of the SPI engine plus the queue of replies still owed
  class spi_scoreboard;
    logic                 enable, lsb_first, cpol, cpha;
    logic [1:0]           rate;
    logic [DATA_BITS-1:0] shreg, rx_word;
    int                   bits_left;
    int unsigned          prescale;
    logic                 clk_active, done, coll, running, mosi, sampled;
    out_item_t            owed_replies[$];
    int                   errors;

    function new();
      enable = 0; lsb_first = 0; cpol = 0; cpha = 0; rate = 0;
      shreg = '0; rx_word = '0; bits_left = 0; prescale = 0;
      clk_active = 0; done = 0; coll = 0; running = 0; mosi = 0; sampled = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // Ticks per half period of the serial clock
    function int half_ticks(logic [1:0] sel);
      case (sel)
        2'd0:    return 2;
        2'd1:    return 8;
        2'd2:    return 32;
        default: return 64;
      endcase
    endfunction

    function logic next_mosi();
      return lsb_first ? shreg[0] : shreg[DATA_BITS-1];
    endfunction

    function void shift_in(logic b);
      if (lsb_first) shreg = {b, shreg[DATA_BITS-1:1]};
      else shreg = {shreg[DATA_BITS-2:0], b};
    endfunction

    function void end_word();
      running = 0;
      rx_word = shreg;
      done = 1;
    endfunction

    // One serial clock edge; leading when the clock leaves its idle level
    function void serial_edge(logic miso);
      if (!clk_active) begin
        clk_active = 1;
        if (cpha) begin
          mosi = next_mosi();
        end else begin
          sampled = miso;
          if (bits_left != 0) bits_left--;
        end
      end else begin
        clk_active = 0;
        if (cpha) begin
          shift_in(miso);
          if (bits_left != 0) bits_left--;
          if (bits_left == 0) end_word();
        end else begin
          shift_in(sampled);
          if (bits_left == 0) end_word();
          else mosi = next_mosi();
        end
      end
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SPI_ENABLE: begin
          enable = val[0];
          // disabling mid-transfer aborts it, clock back to idle, no done
          if (!enable && running) begin
            running = 0; clk_active = 0; bits_left = 0; prescale = 0;
          end
        end
        CFG_LSB_FIRST:      lsb_first = val[0];
        CFG_CLOCK_POLARITY: cpol = val[0];
        CFG_CLOCK_PHASE:    cpha = val[0];
        CFG_RATE_SELECT:    rate = val;
        default: ;
      endcase
    endfunction

    // Accepted input item: update the mirror and queue the reply it owes
    function void note_request(in_item_t req);
      out_item_t rep;
      rep = '0;
      case (req.req_type)
        REQ_WRITE_DATA: begin
          if (running) begin
            coll = 1;
          end else if (enable) begin
            shreg = req.write_data;
            running = 1;
            bits_left = DATA_BITS;
            prescale = 0;
            clk_active = 0;
            if (!cpha) mosi = next_mosi();
          end
        end
        REQ_READ_DATA: rep.read_data = rx_word[7:0];
        REQ_READ_STATUS: begin
          rep.read_data[STATUS_DONE_BIT] = done;
          rep.read_data[STATUS_COLL_BIT] = coll;
        end
        REQ_WRITE_STATUS: begin
          if (req.write_data[STATUS_DONE_BIT]) done = 0;
          if (req.write_data[STATUS_COLL_BIT]) coll = 0;
        end
        REQ_TICK: begin
          if (running) begin
            if (prescale + 1 >= half_ticks(rate)) begin
              prescale = 0;
              serial_edge(req.serial_data_in);
            end else begin
              prescale = (prescale + 1) % 128;
            end
          end
        end
        default: ;
      endcase
      rep.serial_clock    = clk_active ^ cpol;
      rep.serial_data_out = mosi;
      rep.done_flag       = done;
      rep.collision_flag  = coll;
      rep.busy_out        = running;
      owed_replies.push_back(rep);
    endfunction

    function void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    // Accepted result item: compare with the oldest owed reply
    function void check_reply(out_item_t got);
      out_item_t exp;
      if (owed_replies.size() == 0) begin
        $display("%0t: reply with none owed, expected nothing, actual %p", $time, got);
        errors++;
        return;
      end
      exp = owed_replies.pop_front();
      check_field("read_data", 32'(exp.read_data), 32'(got.read_data));
      check_field("serial_clock", 32'(exp.serial_clock), 32'(got.serial_clock));
      check_field("serial_data_out", 32'(exp.serial_data_out), 32'(got.serial_data_out));
      check_field("done_flag", 32'(exp.done_flag), 32'(got.done_flag));
      check_field("collision_flag", 32'(exp.collision_flag), 32'(got.collision_flag));
      check_field("busy_out", 32'(exp.busy_out), 32'(got.busy_out));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spi_scoreboard sb;
  bit            gaps_on = 1'b1;
  bit            hold_request = 1'b0;
  int            n_sent = 0;

  always #5 clk = ~clk;

  spi_master_byte_transfer #(.DATA_BITS(DATA_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Offer one request item, with random gaps before it, until accepted
  task automatic send_req(input logic [2:0] kind, input logic [7:0] data, input logic miso);
    in_item_t req;
    req.req_type = kind;
    req.write_data = data;
    req.serial_data_in = miso;
    // both sides run without idling over one stretch of items
    gaps_on = !(n_sent >= NO_GAP_FIRST && n_sent < NO_GAP_LAST);
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    n_sent++;
  endtask

  task automatic send_noise();
    send_req(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Stop offering and wait until every owed reply has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all five registers back to back
  task automatic program_regs(input logic en, input logic lsb, input logic pol,
                              input logic pha, input logic [1:0] sel);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    idx = '{CFG_SPI_ENABLE, CFG_LSB_FIRST, CFG_CLOCK_POLARITY, CFG_CLOCK_PHASE,
            CFG_RATE_SELECT};
    val = '{{1'b0, en}, {1'b0, lsb}, {1'b0, pol}, {1'b0, pha}, sel};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.apply_config(idx[i], val[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold on request, checks each result item
  initial begin
    int hold_left;
    hold_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_reply(out_item);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
      end
    end
  end

  // Watchdog: too long without any item moving on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("spi_master_byte_transfer verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    int         phase;
    int         n_ticks;
    int         full_ticks;
    int         pick;
    logic       en;
    logic [1:0] sel;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: disabled block, reserved codes, start, collision, flag clears
    drain_replies();
    program_regs(1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_req(REQ_WRITE_DATA, 8'hA5, 1'b1);
    send_req(REQ_TICK, 8'h00, 1'b1);
    for (int r = REQ_RESERVED_LO; r <= REQ_RESERVED_HI; r++) send_req(3'(r), 8'hFF, 1'b1);
    send_req(REQ_READ_DATA, 8'h00, 1'b0);
    send_req(REQ_READ_STATUS, 8'h00, 1'b0);
    drain_replies();
    program_regs(1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
    send_req(REQ_WRITE_DATA, 8'hFF, 1'b0);
    send_req(REQ_WRITE_DATA, 8'h00, 1'b1);
    send_req(REQ_READ_STATUS, 8'h00, 1'b0);
    send_req(REQ_WRITE_STATUS, 8'h40, 1'b0);
    send_req(REQ_WRITE_STATUS, 8'h00, 1'b1);
    for (int i = 0; i < 12; i++) send_req(REQ_TICK, 8'h00, i[0]);

    // Random phases: new settings, then mostly a transfer with noise mixed in
    n_sent = 0;
    phase = 0;
    while (n_sent < RANDOM_ITEMS) begin
      drain_replies();
      en = ($urandom_range(9) != 0);
      pick = $urandom_range(99);
      if (phase == 1) sel = 2'd3;
      else if (pick < 70) sel = 2'd0;
      else if (pick < 90) sel = 2'd1;
      else if (pick < 96) sel = 2'd2;
      else sel = 2'd3;
      program_regs(en, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), sel);
      if (phase == 0) hold_request = 1'b1;

      if ($urandom_range(9) == 0) begin
        repeat (20) send_noise();
      end else begin
        full_ticks = 16 * sb.half_ticks(sel);
        // a cut-short transfer leaves the next settings to land mid-transfer
        if ($urandom_range(3) == 0) n_ticks = $urandom_range(full_ticks - 1, 1);
        else n_ticks = full_ticks + $urandom_range(4);
        send_req(REQ_WRITE_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int t = 0; t < n_ticks; t++) begin
          if ($urandom_range(99) < 15) send_noise();
          send_req(REQ_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        send_req(REQ_READ_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_req(REQ_READ_STATUS, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_req(REQ_WRITE_STATUS, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      phase++;
    end

    drain_replies();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("spi_master_byte_transfer verification clean");
    end else begin
      $display("spi_master_byte_transfer verification failed");
    end
    $finish;
  end

endmodule
